@@ hdl/mrwf_pkg.sv @@
package mrwf_pkg;

  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FUNC_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic        OPCODE_SINGLE     = 1'b0;
  localparam logic        REG_SLAVE_ADDRESS = 1'b0;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    JOB_SINGLE,
    JOB_FIRST,
    JOB_VALUE
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic        last;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [6:0]  count;
    logic [15:0] value;
  } job_t;

  typedef struct packed {
    logic       in_frame;
    logic [6:0] values_left;
  } front_status_t;

  typedef enum logic [3:0] {
    STEP_SLAVE,
    STEP_FUNC,
    STEP_ADDR_H,
    STEP_ADDR_L,
    STEP_CNT_H,
    STEP_CNT_L,
    STEP_BYTES,
    STEP_VAL_H,
    STEP_VAL_L,
    STEP_CRC_L,
    STEP_CRC_H
  } step_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/mrwf_front.sv @@
module mrwf_front #(
  parameter int MAX_WRITE_REGS = 123
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic                   opcode,
  input  logic [15:0]            register_address,
  input  logic [6:0]             register_count,
  input  logic [15:0]            register_value,
  input  logic [7:0]             slave_address,
  output mrwf_pkg::job_t         job,
  output mrwf_pkg::front_status_t status
);
  import mrwf_pkg::*;

  localparam logic [6:0] MAX_CNT = 7'(MAX_WRITE_REGS);

  logic       in_frame;
  logic       in_frame_next;
  logic [6:0] values_left;
  logic [6:0] values_left_next;
  logic [6:0] cnt_sat;

  always_comb begin
    if (register_count == 7'd0) begin
      cnt_sat = 7'd1;
    end else if (register_count > MAX_CNT) begin
      cnt_sat = MAX_CNT;
    end else begin
      cnt_sat = register_count;
    end
  end

  // classify the request and track the open frame
  always_comb begin
    job.slave        = slave_address;
    job.addr         = register_address;
    job.count        = cnt_sat;
    job.value        = register_value;
    in_frame_next    = in_frame;
    values_left_next = values_left;
    if (in_frame) begin
      job.kind         = JOB_VALUE;
      job.last         = (values_left == 7'd1);
      values_left_next = values_left - 7'd1;
      in_frame_next    = (values_left != 7'd1);
    end else if (opcode == OPCODE_SINGLE) begin
      job.kind = JOB_SINGLE;
      job.last = 1'b1;
    end else begin
      job.kind         = JOB_FIRST;
      job.last         = (cnt_sat == 7'd1);
      values_left_next = cnt_sat - 7'd1;
      in_frame_next    = (cnt_sat != 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      values_left <= 7'd0;
    end else if (push) begin
      in_frame    <= in_frame_next;
      values_left <= values_left_next;
    end
  end

  assign status.in_frame    = in_frame;
  assign status.values_left = values_left;

endmodule

@@ hdl/mrwf_queue.sv @@
module mrwf_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  mrwf_pkg::job_t                    push_job,
  input  logic                              pop,
  output mrwf_pkg::job_t                    head,
  output logic                              head_valid,
  output logic                              full,
  output logic [mrwf_pkg::QUEUE_CNT_W-1:0]  level
);
  import mrwf_pkg::*;

  job_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QUEUE_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CNT_W'(1);
      end
    end
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign level      = count;

endmodule

@@ hdl/mrwf_back.sv @@
module mrwf_back (
  input  logic           clk,
  input  logic           rst,
  input  mrwf_pkg::job_t head,
  input  logic           head_valid,
  output logic           pop,
  input  logic           m_tready,
  output logic           m_tvalid,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);
  import mrwf_pkg::*;

  step_t       step;
  step_t       step_next;
  step_t       cur;
  logic        started;
  logic        started_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  logic        emit;
  logic        final_step;
  logic [7:0]  byte_out;
  logic        end_out;

  assign emit = head_valid && (!m_tvalid || m_tready);

  always_comb begin
    if (started) begin
      cur = step;
    end else if (head.kind == JOB_VALUE) begin
      cur = STEP_VAL_H;
    end else begin
      cur = STEP_SLAVE;
    end
  end

  // next state
  always_comb begin
    final_step   = (cur == STEP_CRC_H) || (cur == STEP_VAL_L && !head.last);
    step_next    = step;
    started_next = started;
    pop          = 1'b0;
    if (emit) begin
      if (final_step) begin
        pop          = 1'b1;
        started_next = 1'b0;
        step_next    = STEP_SLAVE;
      end else begin
        started_next = 1'b1;
        case (cur)
          STEP_SLAVE:  step_next = STEP_FUNC;
          STEP_FUNC:   step_next = STEP_ADDR_H;
          STEP_ADDR_H: step_next = STEP_ADDR_L;
          STEP_ADDR_L: step_next = (head.kind == JOB_SINGLE) ? STEP_VAL_H : STEP_CNT_H;
          STEP_CNT_H:  step_next = STEP_CNT_L;
          STEP_CNT_L:  step_next = STEP_BYTES;
          STEP_BYTES:  step_next = STEP_VAL_H;
          STEP_VAL_H:  step_next = STEP_VAL_L;
          STEP_VAL_L:  step_next = STEP_CRC_L;
          STEP_CRC_L:  step_next = STEP_CRC_H;
          default:     step_next = STEP_SLAVE;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    end_out = 1'b0;
    case (cur)
      STEP_SLAVE:  byte_out = head.slave;
      STEP_FUNC:   byte_out = (head.kind == JOB_SINGLE) ? FUNC_WRITE_SINGLE : FUNC_WRITE_MULTI;
      STEP_ADDR_H: byte_out = head.addr[15:8];
      STEP_ADDR_L: byte_out = head.addr[7:0];
      STEP_CNT_H:  byte_out = 8'h00;
      STEP_CNT_L:  byte_out = {1'b0, head.count};
      STEP_BYTES:  byte_out = {head.count, 1'b0};
      STEP_VAL_H:  byte_out = head.value[15:8];
      STEP_VAL_L:  byte_out = head.value[7:0];
      STEP_CRC_L:  byte_out = crc[7:0];
      STEP_CRC_H: begin
        byte_out = crc[15:8];
        end_out  = 1'b1;
      end
      default:     byte_out = 8'h00;
    endcase
  end

  always_comb begin
    crc_next = crc;
    if (emit) begin
      case (cur)
        STEP_SLAVE: crc_next = crc_byte(CRC_INIT, byte_out);
        STEP_CRC_L: crc_next = crc;
        STEP_CRC_H: crc_next = CRC_INIT;
        default:    crc_next = crc_byte(crc, byte_out);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= STEP_SLAVE;
      started  <= 1'b0;
      crc      <= CRC_INIT;
      m_tvalid <= 1'b0;
    end else begin
      step    <= step_next;
      started <= started_next;
      crc     <= crc_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_out;
      m_tlast <= end_out;
    end
  end

endmodule

@@ hdl/modbus_rtu_write_request_framer_unit.sv @@
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tdata: opcode, address, count, value
// m_*       out  m_tvalid / m_tready        m_tdata: frame byte, m_tlast: frame end
// apb       in   psel & penable & pwrite    slave_address at 0x0
//
// one byte per cycle leaves a single output register while jobs wait and m_tready is 1
// a request makes the byte sequencer emit 2 to 11 frame bytes: write single 8,
// first write-multiple request 9 (11 if it is also the last), later ones 2 (4 with crc)
// requests enter while the 2-entry job queue has room, also while bytes are stalled
// reset clears the queue, the frame tracking and the crc; slave_address returns to 1
module modbus_rtu_write_request_framer_unit #(
  parameter int MAX_WRITE_REGS = 123
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // opcode[0], register_address[16:1],
                                // register_count[23:17], register_value[39:24]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // frame_byte[7:0]
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mrwf_pkg::*;

  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   head_valid;
  logic [QUEUE_CNT_W-1:0] q_level;
  job_t                   push_job;
  job_t                   head;
  front_status_t          front_st;
  logic [7:0]             slave_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= 8'd1;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SLAVE_ADDRESS) begin
      slave_address <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_SLAVE_ADDRESS) ? {24'h000000, slave_address} : 32'h0;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  mrwf_front #(
    .MAX_WRITE_REGS(MAX_WRITE_REGS)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .opcode           (s_tdata[0]),
    .register_address (s_tdata[16:1]),
    .register_count   (s_tdata[23:17]),
    .register_value   (s_tdata[39:24]),
    .slave_address    (slave_address),
    .job              (push_job),
    .status           (front_st)
  );

  mrwf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full),
    .level      (q_level)
  );

  mrwf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  a_open_frame_has_values: assert property (@(posedge clk) disable iff (rst)
    front_st.in_frame == (front_st.values_left != 7'd0))
    else $error("frame tracking out of step");

  a_queue_level: assert property (@(posedge clk) disable iff (rst)
    q_level <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("job queue overfilled");

  a_pop_needs_job: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty job queue");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule
